// ===== rtl/i2cms_pkg.sv =====
// Shared types and constants for the I2C master transfer sequencer.
`timescale 1ns / 1ps
package i2cms_pkg;

  localparam int COUNT_WIDTH = 16;

  typedef enum logic [2:0] {
    CMD_BEGIN_WRITE = 3'd0,
    CMD_BEGIN_READ  = 3'd1,
    CMD_BYTE_DONE   = 3'd2,
    CMD_STOP_DONE   = 3'd3,
    CMD_CANCEL      = 3'd4,
    CMD_RETRY_OVER  = 3'd5,
    CMD_WRITE_BYTE  = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_START_SEND = 3'd1,
    ACT_SEND_BYTE  = 3'd2,
    ACT_RECEIVE    = 3'd3,
    ACT_STOP       = 3'd4,
    ACT_REQ_BYTE   = 3'd5,
    ACT_WAIT_RETRY = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_SUCCESS   = 2'd0,
    ST_NACK      = 2'd1,
    ST_CANCELLED = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [6:0]  dev_addr;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic        ack;
    logic        bus_error;
  } cmd_item_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  bus_byte;
    logic        last_read;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic [15:0] rx_index;
    logic        restarted;
    logic        done_res;
    status_t     status;
  } res_item_t;

endpackage

// ===== rtl/i2cms_if.sv =====
// Valid/ready channel interfaces for command items and result items.
`timescale 1ns / 1ps
interface i2cms_cmd_if;
  logic                 valid;
  logic                 ready;
  i2cms_pkg::cmd_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cms_res_if;
  logic                 valid;
  logic                 ready;
  i2cms_pkg::res_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/i2c_master_transfer_sequencer.sv =====
// I2C master transfer sequencer: one bus action per host command or controller event.
//
// The request channel carries host commands (begin write, begin read, cancel,
// write byte supplied) and controller events (byte done, stop done, retry
// delay over). Every accepted item yields exactly one item on the response
// channel, holding the next bus action, any received byte and the final status.
// The address_tries register is written through cfg_we/cfg_wdata; the user must
// write it only while idle, and the block itself does not enforce this. An item
// is captured in an input register; the sequencer state and the result register,
// which drives the response, then update as the item advances. One item per cycle
// is sustained while responses are taken; the limit is the single state update per
// item in the sequencing logic. When the response receiver stalls, the result holds
// and the input register fills, after which request ready drops until the result is
// taken. Synchronous reset returns the sequencer to idle, empties both registers and
// sets address_tries to 2.
`timescale 1ns / 1ps
module i2c_master_transfer_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  i2cms_cmd_if.sink   request,
  i2cms_res_if.source response
);
  import i2cms_pkg::*;

  typedef enum logic [7:0] {
    PH_IDLE       = 8'b0000_0001,
    PH_ADDR       = 8'b0000_0010,
    PH_WREQ       = 8'b0000_0100,
    PH_WSEND      = 8'b0000_1000,
    PH_RECV       = 8'b0001_0000,
    PH_STOP_END   = 8'b0010_0000,
    PH_STOP_RETRY = 8'b0100_0000,
    PH_RETRY_WAIT = 8'b1000_0000
  } phase_t;

  logic       [3:0]             address_tries;
  logic                         in_valid;
  cmd_item_t                    in_item;
  logic                         out_valid;
  res_item_t                    out_item;
  logic                         advance;

  phase_t                       phase, phase_next;
  logic                         reading, reading_next;
  logic       [6:0]             target_address, target_address_next;
  logic       [COUNT_WIDTH-1:0] transfer_length, transfer_length_next;
  logic       [COUNT_WIDTH-1:0] byte_count, byte_count_next;
  logic       [3:0]             tries_left, tries_left_next;
  status_t                      pending_status, pending_status_next;
  res_item_t                    res;

  logic       [COUNT_WIDTH-1:0] in_len;
  logic       [COUNT_WIDTH-1:0] count_inc;
  logic       [COUNT_WIDTH:0]   count_inc2;
  logic       [3:0]             tries_dec;

  assign advance        = in_valid && (!out_valid || response.ready);
  assign request.ready  = !in_valid || advance;
  assign response.valid = out_valid;
  assign response.payload = out_item;

  assign in_len     = COUNT_WIDTH'(in_item.length);
  assign count_inc  = byte_count + 1'b1;
  assign count_inc2 = {1'b0, count_inc} + 1'b1;
  assign tries_dec  = tries_left - 4'd1;

  always_comb begin
    phase_next           = phase;
    reading_next         = reading;
    target_address_next  = target_address;
    transfer_length_next = transfer_length;
    byte_count_next      = byte_count;
    tries_left_next      = tries_left;
    pending_status_next  = pending_status;
    res                  = '0;

    unique case (in_item.cmd)
      CMD_BEGIN_WRITE, CMD_BEGIN_READ: begin
        if (phase == PH_IDLE) begin
          reading_next         = in_item.cmd[0];
          target_address_next  = in_item.dev_addr;
          // A read of zero bytes still fetches one.
          transfer_length_next = (in_item.cmd[0] && in_len == '0) ? COUNT_WIDTH'(1) : in_len;
          tries_left_next      = (address_tries == 4'd0) ? 4'd1 : address_tries;
          pending_status_next  = ST_SUCCESS;
          byte_count_next      = '0;
          res.action           = ACT_START_SEND;
          res.bus_byte         = {in_item.dev_addr, in_item.cmd[0]};
          phase_next           = PH_ADDR;
        end
      end
      CMD_BYTE_DONE: begin
        if ((phase == PH_ADDR || phase == PH_WSEND || phase == PH_RECV) &&
            in_item.bus_error) begin
          byte_count_next = '0;
          res.action      = ACT_START_SEND;
          res.bus_byte    = {target_address, reading};
          res.restarted   = 1'b1;
          phase_next      = PH_ADDR;
        end else if (phase == PH_ADDR) begin
          if (!in_item.ack) begin
            res.action = ACT_STOP;
            if (reading || tries_dec == 4'd0) begin
              pending_status_next = ST_NACK;
              phase_next          = PH_STOP_END;
            end else begin
              pending_status_next = ST_SUCCESS;
              phase_next          = PH_STOP_RETRY;
            end
            if (!reading) begin
              tries_left_next = tries_dec;
            end
          end else if (reading) begin
            res.action    = ACT_RECEIVE;
            res.last_read = ({1'b0, count_inc} == {1'b0, transfer_length});
            phase_next    = PH_RECV;
          end else if (byte_count < transfer_length) begin
            res.action = ACT_REQ_BYTE;
            phase_next = PH_WREQ;
          end else begin
            res.action          = ACT_STOP;
            pending_status_next = ST_SUCCESS;
            phase_next          = PH_STOP_END;
          end
        end else if (phase == PH_WSEND) begin
          if (!in_item.ack) begin
            res.action          = ACT_STOP;
            pending_status_next = ST_NACK;
            phase_next          = PH_STOP_END;
          end else if (byte_count < transfer_length) begin
            res.action = ACT_REQ_BYTE;
            phase_next = PH_WREQ;
          end else begin
            res.action          = ACT_STOP;
            pending_status_next = ST_SUCCESS;
            phase_next          = PH_STOP_END;
          end
        end else if (phase == PH_RECV) begin
          res.rx_valid    = 1'b1;
          res.rx_byte     = in_item.data_byte;
          res.rx_index    = 16'(byte_count);
          byte_count_next = count_inc;
          if (count_inc < transfer_length) begin
            res.action    = ACT_RECEIVE;
            res.last_read = (count_inc2 == {1'b0, transfer_length});
            phase_next    = PH_RECV;
          end else begin
            res.action          = ACT_STOP;
            pending_status_next = ST_SUCCESS;
            phase_next          = PH_STOP_END;
          end
        end
      end
      CMD_STOP_DONE: begin
        if (phase == PH_STOP_END) begin
          res.done_res = 1'b1;
          res.status   = pending_status;
          phase_next   = PH_IDLE;
        end else if (phase == PH_STOP_RETRY) begin
          res.action = ACT_WAIT_RETRY;
          phase_next = PH_RETRY_WAIT;
        end
      end
      CMD_CANCEL: begin
        if (phase != PH_IDLE) begin
          res.done_res = 1'b1;
          res.status   = ST_CANCELLED;
          phase_next   = PH_IDLE;
        end
      end
      CMD_RETRY_OVER: begin
        if (phase == PH_RETRY_WAIT) begin
          byte_count_next = '0;
          res.action      = ACT_START_SEND;
          res.bus_byte    = {target_address, reading};
          phase_next      = PH_ADDR;
        end
      end
      CMD_WRITE_BYTE: begin
        if (phase == PH_WREQ) begin
          res.action      = ACT_SEND_BYTE;
          res.bus_byte    = in_item.data_byte;
          byte_count_next = count_inc;
          phase_next      = PH_WSEND;
        end
      end
      default: begin
        // The unused command code leaves the state alone and gives no action.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_tries   <= 4'd2;
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      phase           <= PH_IDLE;
      reading         <= 1'b0;
      target_address  <= '0;
      transfer_length <= '0;
      byte_count      <= '0;
      tries_left      <= '0;
      pending_status  <= ST_SUCCESS;
    end else begin
      if (cfg_we) begin
        address_tries <= cfg_wdata;
      end
      if (request.ready) begin
        in_valid <= request.valid;
      end
      if (advance) begin
        out_valid       <= 1'b1;
        phase           <= phase_next;
        reading         <= reading_next;
        target_address  <= target_address_next;
        transfer_length <= transfer_length_next;
        byte_count      <= byte_count_next;
        tries_left      <= tries_left_next;
        pending_status  <= pending_status_next;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (request.ready && request.valid) begin
      in_item <= request.payload;
    end
    if (advance) begin
      out_item <= res;
    end
  end

endmodule
